[rtl/mdc_pkg.sv]
// Shared types, constants and codes for the method dispatch cache.
package mdc_pkg;

    localparam int ENTRIES    = 1021;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int KEY_W      = 64;
    localparam int VER_W      = 32;
    localparam int FUNC_W     = 2;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int HASH_STEPS = 2;
    localparam int HCNT_W     = $clog2(HASH_STEPS);
    // 2**IDX_W leaves a small remainder modulo ENTRIES, so the slot hash folds on it.
    localparam int FOLD       = (1 << IDX_W) - ENTRIES;
    localparam int CHUNKS     = (KEY_W + IDX_W - 1) / IDX_W;
    localparam int HX_W       = CHUNKS * IDX_W;
    localparam int HSUM_W     = 20;
    localparam int FOLD_W     = 12;
    localparam int UFOLD_W    = IDX_W + 1;

    typedef logic [CHUNKS-1:0][IDX_W-1:0] t_weights;

    // Weight of each ten-bit chunk of the hash value modulo ENTRIES.
    function automatic t_weights chunk_weights();
        t_weights w;
        int       p;
        p = 1;
        for (int k = 0; k < CHUNKS; k++) begin
            w[k] = IDX_W'(p);
            p    = (p * FOLD) % ENTRIES;
        end
        return w;
    endfunction

    localparam t_weights CHUNK_WEIGHT = chunk_weights();

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOOKUP         = 2'd0,
        FUNC_FILL           = 2'd1,
        FUNC_FLUSH_ALL      = 2'd2,
        FUNC_METHOD_CHANGED = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        STAT_HIT         = 2'd0,
        STAT_MISS        = 2'd1,
        STAT_UNCACHEABLE = 2'd2,
        STAT_DONE        = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOOKUP_SEL   = 1'b0,
        CFG_VERSION_MODE = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_HASH,
        ST_READ,
        ST_FILL_WR,
        ST_FLUSH,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key_table;
        logic [KEY_W-1:0] key_sel;
        logic [VER_W-1:0] key_ver;
        logic [KEY_W-1:0] meth;
        logic [KEY_W-1:0] tab;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic hash_step;
        logic rd_hash;
        logic rd_cnt;
        logic wr_fill;
        logic wr_zero;
        logic scan_chk;
        logic cnt_clr;
        logic cnt_inc;
        logic load_rsp;
    } t_dp_cmd;

    typedef struct packed {
        t_func func;
        logic  is_sym;
        logic  full_flush;
        logic  hash_last;
        logic  cnt_zero;
        logic  cnt_last;
        logic  rsp_free;
    } t_dp_status;

endpackage

[rtl/mdc_if.sv]
// Request and response channel interfaces of the method dispatch cache.
interface mdc_req_if;
    logic                          valid;
    logic                          ready;
    logic [mdc_pkg::FUNC_W-1:0]    func;
    logic [mdc_pkg::KEY_W-1:0]     table_ptr;
    logic [mdc_pkg::KEY_W-1:0]     selector;
    logic                          sel_is_symbol;
    logic [mdc_pkg::VER_W-1:0]     sym_version;
    logic [mdc_pkg::KEY_W-1:0]     fill_method;
    logic [mdc_pkg::KEY_W-1:0]     fill_table;

    modport source (
        output valid, func, table_ptr, selector, sel_is_symbol, sym_version,
               fill_method, fill_table,
        input  ready
    );
    modport sink (
        input  valid, func, table_ptr, selector, sel_is_symbol, sym_version,
               fill_method, fill_table,
        output ready
    );
endinterface

interface mdc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mdc_pkg::STAT_W-1:0]    status;
    logic [mdc_pkg::KEY_W-1:0]     hit_method;
    logic [mdc_pkg::KEY_W-1:0]     hit_table;

    modport source (
        output valid, status, hit_method, hit_table,
        input  ready
    );
    modport sink (
        input  valid, status, hit_method, hit_table,
        output ready
    );
endinterface

[rtl/method_dispatch_cache_unit.sv]
// Direct-mapped method dispatch cache with 1021 entries, one request at a time. The slot is
// ((table_ptr << 2) ^ (selector >> 3)) mod 1021, worked out in two hash steps by summing the
// ten-bit chunks with their weights modulo 1021 and folding the sum. A symbol lookup or fill
// passes through capture, decode, two hash steps, memory access and response; non-symbol
// requests go from decode straight to the response. Flush all zeroes every entry, and a
// per-selector method change reads and compares every entry through the single memory
// read port.
// After reset a clearing pass runs before the first request is accepted;
// configuration writes are taken at any time. A finished response waits in an output
// register while the next request is accepted.
module method_dispatch_cache_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mdc_req_if.sink                       i_req,
    mdc_rsp_if.source                     o_rsp,
    input  logic                          i_cfg_we,
    input  logic [mdc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mdc_pkg::KEY_W-1:0]     i_cfg_data
);

    mdc_pkg::t_dp_cmd    dp_cmd;
    mdc_pkg::t_dp_status dp_status;

    mdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    mdc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_dp_status      (dp_status),
        .i_func           (i_req.func),
        .i_table_ptr      (i_req.table_ptr),
        .i_selector       (i_req.selector),
        .i_sel_is_symbol  (i_req.sel_is_symbol),
        .i_sym_version    (i_req.sym_version),
        .i_fill_method    (i_req.fill_method),
        .i_fill_table     (i_req.fill_table),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_rsp_valid      (o_rsp.valid),
        .i_rsp_ready      (o_rsp.ready),
        .o_rsp_status     (o_rsp.status),
        .o_rsp_hit_method (o_rsp.hit_method),
        .o_rsp_hit_table  (o_rsp.hit_table)
    );

endmodule

[rtl/mdc_ctrl.sv]
// Control state machine of the method dispatch cache.
module mdc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mdc_pkg::t_dp_status i_status,
    output mdc_pkg::t_dp_cmd    o_cmd
);

    mdc_pkg::t_state r_state;
    mdc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mdc_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            mdc_pkg::ST_INIT: begin
                // Clearing pass after reset: zero one entry per cycle.
                o_cmd.wr_zero = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = mdc_pkg::ST_IDLE;
                end
            end
            mdc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = mdc_pkg::ST_DISPATCH;
                end
            end
            mdc_pkg::ST_DISPATCH: begin
                o_cmd.cnt_clr = 1'b1;
                case (i_status.func)
                    mdc_pkg::FUNC_LOOKUP,
                    mdc_pkg::FUNC_FILL: begin
                        n_state = i_status.is_sym ? mdc_pkg::ST_HASH : mdc_pkg::ST_RESP;
                    end
                    mdc_pkg::FUNC_FLUSH_ALL: begin
                        n_state = mdc_pkg::ST_FLUSH;
                    end
                    mdc_pkg::FUNC_METHOD_CHANGED: begin
                        n_state = i_status.full_flush ? mdc_pkg::ST_FLUSH : mdc_pkg::ST_SCAN;
                    end
                    default: begin
                        n_state = mdc_pkg::ST_RESP;
                    end
                endcase
            end
            mdc_pkg::ST_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_status.hash_last) begin
                    n_state = (i_status.func == mdc_pkg::FUNC_LOOKUP) ?
                              mdc_pkg::ST_READ : mdc_pkg::ST_FILL_WR;
                end
            end
            mdc_pkg::ST_READ: begin
                o_cmd.rd_hash = 1'b1;
                n_state       = mdc_pkg::ST_RESP;
            end
            mdc_pkg::ST_FILL_WR: begin
                o_cmd.wr_fill = 1'b1;
                n_state       = mdc_pkg::ST_RESP;
            end
            mdc_pkg::ST_FLUSH: begin
                o_cmd.wr_zero = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = mdc_pkg::ST_RESP;
                end
            end
            mdc_pkg::ST_SCAN: begin
                // Read entry n while checking the data of entry n-1.
                o_cmd.rd_cnt   = 1'b1;
                o_cmd.scan_chk = !i_status.cnt_zero;
                o_cmd.cnt_inc  = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = mdc_pkg::ST_SCAN_TAIL;
                end
            end
            mdc_pkg::ST_SCAN_TAIL: begin
                o_cmd.scan_chk = 1'b1;
                n_state        = mdc_pkg::ST_RESP;
            end
            mdc_pkg::ST_RESP: begin
                if (i_status.rsp_free) begin
                    o_cmd.load_rsp = 1'b1;
                    n_state        = mdc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mdc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/mdc_dp.sv]
// Datapath of the method dispatch cache: entry memory, slot hash, compare and response.
module mdc_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mdc_pkg::t_dp_cmd             i_cmd,
    output mdc_pkg::t_dp_status          o_dp_status,
    input  logic [mdc_pkg::FUNC_W-1:0]   i_func,
    input  logic [mdc_pkg::KEY_W-1:0]    i_table_ptr,
    input  logic [mdc_pkg::KEY_W-1:0]    i_selector,
    input  logic                         i_sel_is_symbol,
    input  logic [mdc_pkg::VER_W-1:0]    i_sym_version,
    input  logic [mdc_pkg::KEY_W-1:0]    i_fill_method,
    input  logic [mdc_pkg::KEY_W-1:0]    i_fill_table,
    input  logic                         i_cfg_we,
    input  logic [mdc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mdc_pkg::KEY_W-1:0]    i_cfg_data,
    output logic                         o_rsp_valid,
    input  logic                         i_rsp_ready,
    output logic [mdc_pkg::STAT_W-1:0]   o_rsp_status,
    output logic [mdc_pkg::KEY_W-1:0]    o_rsp_hit_method,
    output logic [mdc_pkg::KEY_W-1:0]    o_rsp_hit_table
);

    // Configuration registers.
    logic [mdc_pkg::KEY_W-1:0]  r_lookup_sel;
    logic                       r_version_mode;

    // Captured request.
    mdc_pkg::t_func             r_func;
    logic [mdc_pkg::KEY_W-1:0]  r_table;
    logic [mdc_pkg::KEY_W-1:0]  r_sel;
    logic                       r_sym;
    logic [mdc_pkg::VER_W-1:0]  r_ver;
    logic [mdc_pkg::KEY_W-1:0]  r_fmeth;
    logic [mdc_pkg::KEY_W-1:0]  r_ftab;

    // Slot hash: weighted chunk sum, then two folds and a final compare.
    logic [mdc_pkg::KEY_W-1:0]  r_hash_val;
    logic [mdc_pkg::HSUM_W-1:0] r_hsum;
    logic [mdc_pkg::HSUM_W-1:0] n_hsum;
    logic [mdc_pkg::IDX_W-1:0]  r_rem;
    logic [mdc_pkg::IDX_W-1:0]  n_rem;
    logic [mdc_pkg::HCNT_W-1:0] r_hcnt;

    // Sweep counter.
    logic [mdc_pkg::CNT_W-1:0]  r_cnt;

    // Entry memory.
    mdc_pkg::t_entry            r_mem [mdc_pkg::ENTRIES];
    mdc_pkg::t_entry            r_rd_data;
    logic [mdc_pkg::IDX_W-1:0]  r_rd_addr;
    logic                       rd_en;
    logic [mdc_pkg::IDX_W-1:0]  rd_addr;
    logic                       wr_en;
    logic [mdc_pkg::IDX_W-1:0]  wr_addr;
    mdc_pkg::t_entry            wr_data;
    logic                       scan_hit;
    logic                       lk_hit;

    // Response register.
    logic                       r_rsp_valid;
    mdc_pkg::t_status           r_rsp_status;
    logic [mdc_pkg::KEY_W-1:0]  r_rsp_meth;
    logic [mdc_pkg::KEY_W-1:0]  r_rsp_tab;
    mdc_pkg::t_status           n_rsp_status;
    logic [mdc_pkg::KEY_W-1:0]  n_rsp_meth;
    logic [mdc_pkg::KEY_W-1:0]  n_rsp_tab;
    logic                       rsp_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookup_sel   <= '0;
            r_version_mode <= 1'b1;
        end else if (i_cfg_we) begin
            case (mdc_pkg::t_cfg_idx'(i_cfg_idx))
                mdc_pkg::CFG_LOOKUP_SEL:   r_lookup_sel   <= i_cfg_data;
                mdc_pkg::CFG_VERSION_MODE: r_version_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= mdc_pkg::t_func'(i_func);
            r_table <= i_table_ptr;
            r_sel   <= i_selector;
            r_sym   <= i_sel_is_symbol;
            r_ver   <= i_sym_version;
            r_fmeth <= i_fill_method;
            r_ftab  <= i_fill_table;
        end
    end

    // Each ten-bit chunk of the hash value is weighted by 2**(10k) modulo ENTRIES,
    // which keeps the sum below 2**HSUM_W.
    always_comb begin
        logic [mdc_pkg::HX_W-1:0] hx;
        hx     = mdc_pkg::HX_W'(r_hash_val);
        n_hsum = '0;
        for (int k = 0; k < mdc_pkg::CHUNKS; k++) begin
            n_hsum = n_hsum +
                     mdc_pkg::HSUM_W'(hx[k*mdc_pkg::IDX_W +: mdc_pkg::IDX_W]) *
                     mdc_pkg::HSUM_W'(mdc_pkg::CHUNK_WEIGHT[k]);
        end
    end

    // Two folds on 2**IDX_W bring the sum below ENTRIES + FOLD**2, and one
    // conditional subtraction finishes the remainder.
    always_comb begin
        logic [mdc_pkg::FOLD_W-1:0]  t;
        logic [mdc_pkg::UFOLD_W-1:0] u;
        t = mdc_pkg::FOLD_W'(r_hsum[mdc_pkg::HSUM_W-1:mdc_pkg::IDX_W]) *
            mdc_pkg::FOLD_W'(mdc_pkg::FOLD) +
            mdc_pkg::FOLD_W'(r_hsum[mdc_pkg::IDX_W-1:0]);
        u = mdc_pkg::UFOLD_W'(t[mdc_pkg::FOLD_W-1:mdc_pkg::IDX_W]) *
            mdc_pkg::UFOLD_W'(mdc_pkg::FOLD) +
            mdc_pkg::UFOLD_W'(t[mdc_pkg::IDX_W-1:0]);
        if (u >= mdc_pkg::UFOLD_W'(mdc_pkg::ENTRIES)) begin
            u = u - mdc_pkg::UFOLD_W'(mdc_pkg::ENTRIES);
        end
        n_rem = u[mdc_pkg::IDX_W-1:0];
    end

    // The first hash step registers the chunk sum and the second folds it into the slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hsum <= '0;
            r_rem  <= '0;
            r_hcnt <= '0;
        end else if (i_cmd.capture) begin
            r_rem  <= '0;
            r_hcnt <= '0;
        end else if (i_cmd.hash_step) begin
            r_hsum <= n_hsum;
            r_rem  <= n_rem;
            r_hcnt <= r_hcnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_hash_val <= (i_table_ptr << 2) ^ (i_selector >> 3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_comb begin
        rd_en    = i_cmd.rd_hash | i_cmd.rd_cnt;
        rd_addr  = i_cmd.rd_hash ? r_rem : r_cnt[mdc_pkg::IDX_W-1:0];
        scan_hit = i_cmd.scan_chk && (r_rd_data.key_sel == r_sel);
        wr_en    = i_cmd.wr_fill | i_cmd.wr_zero | scan_hit;
        if (i_cmd.wr_fill) begin
            wr_addr = r_rem;
        end else if (i_cmd.wr_zero) begin
            wr_addr = r_cnt[mdc_pkg::IDX_W-1:0];
        end else begin
            wr_addr = r_rd_addr;
        end
        wr_data = '0;
        if (i_cmd.wr_fill) begin
            wr_data.valid     = 1'b1;
            wr_data.key_table = r_table;
            wr_data.key_sel   = r_sel;
            wr_data.key_ver   = r_ver;
            wr_data.meth      = r_fmeth;
            wr_data.tab       = r_ftab;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_addr <= rd_addr;
        end
    end

    always_comb begin
        lk_hit = r_rd_data.valid && (r_rd_data.key_table == r_table) &&
                 (r_rd_data.key_sel == r_sel) &&
                 (!r_version_mode || (r_rd_data.key_ver == r_ver));
        n_rsp_status = mdc_pkg::STAT_DONE;
        n_rsp_meth   = '0;
        n_rsp_tab    = '0;
        if (r_func == mdc_pkg::FUNC_LOOKUP) begin
            if (!r_sym) begin
                n_rsp_status = mdc_pkg::STAT_UNCACHEABLE;
            end else if (lk_hit) begin
                n_rsp_status = mdc_pkg::STAT_HIT;
                n_rsp_meth   = r_rd_data.meth;
                n_rsp_tab    = r_rd_data.tab;
            end else begin
                n_rsp_status = mdc_pkg::STAT_MISS;
            end
        end
    end

    assign rsp_free = !r_rsp_valid || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.load_rsp) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rsp) begin
            r_rsp_status <= n_rsp_status;
            r_rsp_meth   <= n_rsp_meth;
            r_rsp_tab    <= n_rsp_tab;
        end
    end

    assign o_rsp_valid      = r_rsp_valid;
    assign o_rsp_status     = r_rsp_status;
    assign o_rsp_hit_method = r_rsp_meth;
    assign o_rsp_hit_table  = r_rsp_tab;

    always_comb begin
        o_dp_status            = '0;
        o_dp_status.func       = r_func;
        o_dp_status.is_sym     = r_sym;
        o_dp_status.full_flush = !r_version_mode || (r_sel == r_lookup_sel);
        o_dp_status.hash_last  = (r_hcnt == mdc_pkg::HCNT_W'(mdc_pkg::HASH_STEPS - 1));
        o_dp_status.cnt_zero   = (r_cnt == '0);
        o_dp_status.cnt_last   = (r_cnt == mdc_pkg::CNT_W'(mdc_pkg::ENTRIES - 1));
        o_dp_status.rsp_free   = rsp_free;
    end

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem < mdc_pkg::ENTRIES)
        else $error("slot remainder out of range");

    a_wr_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (wr_addr < mdc_pkg::ENTRIES))
        else $error("memory write beyond last entry");

    a_no_rsp_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_rsp |-> (!r_rsp_valid || i_rsp_ready))
        else $error("response loaded over a pending response");

    a_one_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.wr_fill, i_cmd.wr_zero, i_cmd.scan_chk}))
        else $error("more than one memory write source active");

endmodule

[tb/sv/mdc_dispatch_checker.sv]
// Checker for the method dispatch cache: mirrors the cache, predicts each response and compares.
module mdc_dispatch_checker
    import mdc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mdc_req_if                   req,
    mdc_rsp_if                   rsp,
    input  logic                 i_cfg_we,
    input  t_cfg_idx             i_cfg_idx,
    input  logic [KEY_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_status          status;
        logic [KEY_W-1:0] meth;
        logic [KEY_W-1:0] tab;
    } dispatch_rsp_t;

    // Mirror of the cache contents and its two registers.
    logic             slot_live   [ENTRIES];
    logic [KEY_W-1:0] slot_table  [ENTRIES];
    logic [KEY_W-1:0] slot_sel    [ENTRIES];
    logic [VER_W-1:0] slot_ver    [ENTRIES];
    logic [KEY_W-1:0] slot_meth   [ENTRIES];
    logic [KEY_W-1:0] slot_deftab [ENTRIES];
    logic [KEY_W-1:0] flush_sel;
    logic             version_on;

    dispatch_rsp_t awaited_rsp[$];
    dispatch_rsp_t want;
    int            fails = 0;

    function automatic int unsigned slot_for(logic [KEY_W-1:0] tp, logic [KEY_W-1:0] sl);
        logic [KEY_W-1:0] h;
        h = (tp << 2) ^ (sl >> 3);
        return int'(h % 64'(ENTRIES));
    endfunction

    function automatic void wipe_slot(int unsigned i);
        slot_live[i]   = 1'b0;
        slot_table[i]  = '0;
        slot_sel[i]    = '0;
        slot_ver[i]    = '0;
        slot_meth[i]   = '0;
        slot_deftab[i] = '0;
    endfunction

    function automatic void wipe_cache();
        for (int unsigned i = 0; i < ENTRIES; i++) wipe_slot(i);
    endfunction

    // Applies one request to the mirror and returns the response it must produce.
    function automatic dispatch_rsp_t serve_request(
        t_func fn, logic [KEY_W-1:0] tp, logic [KEY_W-1:0] sl, logic sym,
        logic [VER_W-1:0] vr, logic [KEY_W-1:0] fm, logic [KEY_W-1:0] ft);
        dispatch_rsp_t r;
        int unsigned   i;
        r.status = STAT_DONE;
        r.meth   = '0;
        r.tab    = '0;
        i = slot_for(tp, sl);
        case (fn)
            FUNC_LOOKUP: begin
                if (!sym) begin
                    r.status = STAT_UNCACHEABLE;
                end else if (slot_live[i] && slot_table[i] == tp && slot_sel[i] == sl &&
                             (!version_on || slot_ver[i] == vr)) begin
                    r.status = STAT_HIT;
                    r.meth   = slot_meth[i];
                    r.tab    = slot_deftab[i];
                end else begin
                    r.status = STAT_MISS;
                end
            end
            FUNC_FILL: begin
                // The version is stored even when versions are not compared.
                if (sym) begin
                    slot_live[i]   = 1'b1;
                    slot_table[i]  = tp;
                    slot_sel[i]    = sl;
                    slot_ver[i]    = vr;
                    slot_meth[i]   = fm;
                    slot_deftab[i] = ft;
                end
            end
            FUNC_FLUSH_ALL: wipe_cache();
            default: begin
                // Invalid slots whose selector matches are cleared as well.
                if (!version_on || sl == flush_sel) begin
                    wipe_cache();
                end else begin
                    for (int unsigned j = 0; j < ENTRIES; j++)
                        if (slot_sel[j] == sl) wipe_slot(j);
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wipe_cache();
            flush_sel  = '0;
            version_on = 1'b1;
            awaited_rsp.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LOOKUP_SEL:   flush_sel  = i_cfg_data;
                    CFG_VERSION_MODE: version_on = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
                awaited_rsp.push_back(serve_request(t_func'(req.func), req.table_ptr,
                    req.selector, req.sel_is_symbol, req.sym_version, req.fill_method,
                    req.fill_table));
            if (rsp.valid && rsp.ready) begin
                if (awaited_rsp.size() == 0) begin
                    if (fails < 10)
                        $display("%0t: response with no request outstanding: status %0d",
                                 $realtime, rsp.status);
                    fails++;
                end else begin
                    want = awaited_rsp.pop_front();
                    if (rsp.status !== want.status || rsp.hit_method !== want.meth ||
                        rsp.hit_table !== want.tab) begin
                        if (fails < 10)
                            $display({"%0t: response mismatch: status exp %0d got %0d, ",
                                      "method exp %h got %h, table exp %h got %h"},
                                     $realtime, want.status, rsp.status, want.meth,
                                     rsp.hit_method, want.tab, rsp.hit_table);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= awaited_rsp.size();
        o_fail_count <= fails;
    end

endmodule

[tb/sv/tb_method_dispatch_cache_unit.sv]
// Testbench top for the method dispatch cache: clock, reset, request stimulus and verdict.
module tb_method_dispatch_cache_unit;
    import mdc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  POOL        = 12;
    localparam int  PHASES      = 5;
    localparam int  PHASE_ITEMS = 356;
    localparam int  IDLE_PCT    = 29;
    localparam longint CYCLE_LIMIT = 20_000_000;

    typedef struct {
        logic [KEY_W-1:0] tbl;
        logic [KEY_W-1:0] sel;
        logic [VER_W-1:0] ver;
    } cache_key_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    t_cfg_idx         cfg_idx;
    logic [KEY_W-1:0] cfg_data;
    int               check_fails;
    int               pending;
    logic             calm;
    longint           cycles = 0;

    cache_key_t       keys [POOL];
    logic [KEY_W-1:0] cur_flush_sel;

    mdc_req_if req_ch ();
    mdc_rsp_if rsp_ch ();

    method_dispatch_cache_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    mdc_dispatch_checker u_dispatch_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (check_fails),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Response back-pressure.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready = (!calm && $urandom_range(99) < IDLE_PCT) ? 1'b0 : 1'b1;
        end
    end

    function automatic logic [KEY_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Offers one request and returns at the edge where it is taken.
    task automatic send_request(t_func fn, logic [KEY_W-1:0] tp, logic [KEY_W-1:0] sl,
                                logic sym, logic [VER_W-1:0] vr, logic [KEY_W-1:0] fm,
                                logic [KEY_W-1:0] ft);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid         = 1'b1;
        req_ch.func          = fn;
        req_ch.table_ptr     = tp;
        req_ch.selector      = sl;
        req_ch.sel_is_symbol = sym;
        req_ch.sym_version   = vr;
        req_ch.fill_method   = fm;
        req_ch.fill_table    = ft;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [KEY_W-1:0] data);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge i_clk);
        cfg_we   = 1'b0;
    endtask

    // Keys are built in groups so that several share a selector or land on one slot:
    // flipping the two top table bits or the three low selector bits keeps the slot.
    task automatic build_pool();
        for (int k = 0; k < POOL; k++) begin
            keys[k].tbl = rand64();
            keys[k].sel = rand64();
            keys[k].ver = $urandom;
            case (k % 4)
                1: keys[k].sel = keys[k-1].sel;
                2: begin
                    keys[k].tbl = keys[k-1].tbl ^ {2'($urandom_range(3, 1)), 62'd0};
                    keys[k].sel = keys[k-1].sel;
                end
                3: begin
                    keys[k].tbl = keys[k-1].tbl;
                    keys[k].sel = keys[k-1].sel ^ 64'($urandom_range(7, 1));
                end
                default: ;
            endcase
        end
    endtask

    task automatic random_request();
        int               r;
        int               k;
        int               m;
        cache_key_t       ky;
        logic             sym;
        logic [VER_W-1:0] vr;
        logic [KEY_W-1:0] sl;
        r   = $urandom_range(999);
        k   = $urandom_range(POOL - 1);
        ky  = keys[k];
        sym = ($urandom_range(99) >= 8);
        vr  = ($urandom_range(99) < 80) ? ky.ver : VER_W'($urandom);
        if (r < 450) begin
            send_request(FUNC_LOOKUP, ky.tbl, ky.sel, sym, vr, rand64(), rand64());
        end else if (r < 750) begin
            send_request(FUNC_FILL, ky.tbl, ky.sel, sym, vr, rand64(), rand64());
        end else if (r < 830) begin
            send_request(FUNC_LOOKUP, rand64(), rand64(), 1'($urandom), $urandom,
                         rand64(), rand64());
        end else if (r < 880) begin
            m  = $urandom_range(99);
            sl = (m < 70) ? ky.sel : (m < 85) ? cur_flush_sel : rand64();
            // A method change moves the selector to a new version.
            for (int j = 0; j < POOL; j++)
                if (keys[j].sel == sl) keys[j].ver = $urandom;
            send_request(FUNC_METHOD_CHANGED, rand64(), sl, 1'($urandom), $urandom,
                         rand64(), rand64());
        end else if (r < 895) begin
            send_request(FUNC_FLUSH_ALL, rand64(), rand64(), 1'($urandom), $urandom,
                         rand64(), rand64());
        end else begin
            send_request(FUNC_FILL, rand64(), rand64(), 1'($urandom), $urandom,
                         rand64(), rand64());
        end
    endtask

    initial begin
        logic [KEY_W-1:0] ones;
        logic [KEY_W-1:0] alias_tbl;
        logic [KEY_W-1:0] c_tbl;
        logic [KEY_W-1:0] c_sel;
        logic [KEY_W-1:0] c_meth;
        logic [KEY_W-1:0] b_meth;

        ones                 = '1;
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = CFG_LOOKUP_SEL;
        cfg_data             = '0;
        calm                 = 1'b0;
        cur_flush_sel        = '0;
        req_ch.valid         = 1'b0;
        req_ch.func          = FUNC_LOOKUP;
        req_ch.table_ptr     = '0;
        req_ch.selector      = '0;
        req_ch.sel_is_symbol = 1'b0;
        req_ch.sym_version   = '0;
        req_ch.fill_method   = '0;
        req_ch.fill_table    = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part with the reset settings: lookup selector zero, versions compared.
        alias_tbl = ones ^ {2'b01, 62'd0};
        c_tbl     = 64'h0123_4567_89ab_cdef;
        c_sel     = 64'hfedc_ba98_7654_3210;
        c_meth    = rand64();
        b_meth    = rand64();
        send_request(FUNC_LOOKUP, '0, '0, 1'b1, '0, '0, '0);
        send_request(FUNC_FILL, '0, '0, 1'b1, '0, ones, ones);
        send_request(FUNC_LOOKUP, '0, '0, 1'b1, '0, '0, '0);
        send_request(FUNC_LOOKUP, '0, '0, 1'b1, '1, '0, '0);
        send_request(FUNC_LOOKUP, '0, '0, 1'b0, '0, ones, ones);
        send_request(FUNC_FILL, ones, ones, 1'b0, '1, ones, ones);
        send_request(FUNC_LOOKUP, ones, ones, 1'b1, '1, '0, '0);
        // A not-found answer is cached like any other.
        send_request(FUNC_FILL, ones, ones, 1'b1, '1, '0, '0);
        send_request(FUNC_LOOKUP, ones, ones, 1'b1, '1, ones, ones);
        // Same slot, different table: the older entry is evicted.
        send_request(FUNC_FILL, alias_tbl, ones, 1'b1, '1, b_meth, c_tbl);
        send_request(FUNC_LOOKUP, ones, ones, 1'b1, '1, '0, '0);
        send_request(FUNC_LOOKUP, alias_tbl, ones, 1'b1, '1, '0, '0);
        send_request(FUNC_FILL, c_tbl, c_sel, 1'b1, 32'h5a5a_a5a5, c_meth, c_sel);
        send_request(FUNC_LOOKUP, c_tbl, c_sel, 1'b1, 32'h5a5a_a5a5, '0, '0);
        send_request(FUNC_METHOD_CHANGED, '0, c_sel, 1'b1, '0, '0, '0);
        send_request(FUNC_LOOKUP, c_tbl, c_sel, 1'b1, 32'h5a5a_a5a5, '0, '0);
        send_request(FUNC_LOOKUP, alias_tbl, ones, 1'b1, '1, '0, '0);
        // A change of the lookup selector itself empties the whole cache.
        send_request(FUNC_METHOD_CHANGED, ones, '0, 1'b0, '1, ones, ones);
        send_request(FUNC_LOOKUP, alias_tbl, ones, 1'b1, '1, '0, '0);
        send_request(FUNC_FILL, alias_tbl, ones, 1'b1, '0, b_meth, ones);
        send_request(FUNC_LOOKUP, alias_tbl, ones, 1'b1, '0, '0, '0);
        send_request(FUNC_FLUSH_ALL, ones, ones, 1'b1, '1, ones, ones);
        send_request(FUNC_LOOKUP, alias_tbl, ones, 1'b1, '0, '0, '0);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            build_pool();
            case (ph)
                0: begin
                    cur_flush_sel = ones;
                    write_cfg(CFG_VERSION_MODE, {63'(rand64()), 1'b0});
                end
                1: begin
                    cur_flush_sel = keys[0].sel;
                    write_cfg(CFG_VERSION_MODE, 64'd1);
                end
                2: begin
                    cur_flush_sel = '0;
                    calm          = 1'b1;
                end
                3: begin
                    cur_flush_sel = rand64();
                    write_cfg(CFG_VERSION_MODE, {63'(rand64()), 1'b0});
                end
                default: begin
                    cur_flush_sel = keys[4].sel;
                    write_cfg(CFG_VERSION_MODE, {63'(rand64()), 1'b1});
                end
            endcase
            write_cfg(CFG_LOOKUP_SEL, cur_flush_sel);
            repeat (PHASE_ITEMS) random_request();
            calm = 1'b0;
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (check_fails == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
